[rtl/core/esc_pkg.sv]
package esc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_TEMP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_A = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_B = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MIXED   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM     = 3'd4;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [47:0] mixed;
    logic [39:0] hum;
  } cfg_t;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
    logic [31:0] ta;
    logic [31:0] xx;
  } front_item_t;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [31:0] sx16_32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] mul64x16s(logic [63:0] a, logic [15:0] b);
    logic signed [63:0] sa;
    logic signed [15:0] sb;
    logic signed [63:0] r;
    sa = a;
    sb = b;
    r  = sa * sb;
    return r;
  endfunction

endpackage

[rtl/core/esc_front.sv]
module esc_front import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [15:0] raw_humidity_i,
  output logic        item_valid_o,
  output front_item_t item_o,
  input  logic        item_ready_i
);

  logic        vld_q, vld_d;
  front_item_t item_q;
  logic        accept;
  logic [15:0] t1, t2;
  logic [31:0] d1, dx, ta, xx;

  assign t1 = cfg_i.temp[15:0];
  assign t2 = cfg_i.temp[31:16];

  assign in_ready_o = !vld_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // first temperature products
  assign d1 = {15'b0, raw_temperature_i[19:3]} - {15'b0, t1, 1'b0};
  assign ta = d1 * sx16_32(t2);
  assign dx = {16'b0, raw_temperature_i[19:4]} - {16'b0, t1};
  assign xx = dx * dx;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (item_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.raw_t <= raw_temperature_i;
      item_q.raw_p <= raw_pressure_i;
      item_q.raw_h <= raw_humidity_i;
      item_q.ta    <= ta;
      item_q.xx    <= xx;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

[rtl/core/esc_queue.sv]
module esc_queue import esc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  front_item_t push_item_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output front_item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  front_item_t           mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/core/esc_back.sv]
module esc_back import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  front_item_t item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] temp_o,
  output logic [31:0] press_o,
  output logic [16:0] hum_o
);

  localparam int unsigned Stages   = 80;
  localparam int unsigned DivBits  = 64;
  localparam int unsigned TempLine = 78;
  localparam int unsigned HumLine  = 67;

  logic        en;
  logic [Stages-1:0] vld_q;

  logic [15:0] t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic [7:0]  h1, h3, h6;

  assign t3 = cfg_i.temp[47:32];
  assign p1 = cfg_i.press_a[15:0];
  assign p2 = cfg_i.press_a[31:16];
  assign p3 = cfg_i.press_a[47:32];
  assign p4 = cfg_i.press_a[63:48];
  assign p5 = cfg_i.press_b[15:0];
  assign p6 = cfg_i.press_b[31:16];
  assign p7 = cfg_i.press_b[47:32];
  assign p8 = cfg_i.press_b[63:48];
  assign p9 = cfg_i.mixed[15:0];
  assign h1 = cfg_i.mixed[23:16];
  assign h2 = cfg_i.mixed[39:24];
  assign h3 = cfg_i.mixed[47:40];
  assign h4 = cfg_i.hum[15:0];
  assign h5 = cfg_i.hum[31:16];
  assign h6 = cfg_i.hum[39:32];

  assign en           = !vld_q[Stages-1] || out_ready_i;
  assign item_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], item_valid_i};
    end
  end

  // temperature
  logic [31:0] s1_a_q, s1_bb_q, s2_tf_q;
  logic [19:0] s1_ap_q, s2_ap_q, s3_ap_q, s4_ap_q, s5_ap_q, s6_ap_q;
  logic [15:0] s1_ah_q, s2_ah_q, s3_ah_q;
  logic [31:0] s1_bb_d, s3_tmp, s3_temp_d;
  logic [63:0] s3_v1_q;
  logic [31:0] s3_hv_q;
  logic [31:0] temp_line_q [TempLine];

  assign s1_bb_d   = asr32(item_i.xx, 12) * sx16_32(t3);
  assign s3_tmp    = s2_tf_q * 32'd50;
  assign s3_temp_d = asr32(s3_tmp + 32'd128, 8);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q  <= asr32(item_i.ta, 11);
      s1_bb_q <= s1_bb_d;
      s1_ap_q <= item_i.raw_p;
      s1_ah_q <= item_i.raw_h;
      s2_tf_q <= s1_a_q + asr32(s1_bb_q, 14);
      s2_ap_q <= s1_ap_q;
      s2_ah_q <= s1_ah_q;
      s3_v1_q <= {{32{s2_tf_q[31]}}, s2_tf_q} - 64'd128000;
      s3_hv_q <= s2_tf_q - 32'd76800;
      s3_ap_q <= s2_ap_q;
      s3_ah_q <= s2_ah_q;
      temp_line_q[0] <= s3_temp_d;
      for (int k = 1; k < TempLine; k++) begin
        temp_line_q[k] <= temp_line_q[k-1];
      end
    end
  end

  // pressure front half
  logic signed [32:0] v1s;
  logic signed [65:0] vv_full;
  logic signed [48:0] v1p5_full, v1p2_full;
  logic [63:0] s4_vv_q, s4_v1p5_q, s4_v1p2_q;
  logic [63:0] s5_v2a_q, s5_vv3_q, s5_v1p5_q, s5_v1p2_q;
  logic [63:0] s6_v2_q, s6_v1c_q;
  logic [63:0] s7_m_q, s7_n0_q, s7_m_d, s7_pp;
  logic [63:0] s8_den_q, s8_num_q, s8_num_d;

  assign v1s       = s3_v1_q[32:0];
  assign vv_full   = v1s * v1s;
  assign v1p5_full = v1s * $signed(p5);
  assign v1p2_full = v1s * $signed(p2);
  assign s7_m_d    = s6_v1c_q * {48'b0, p1};
  assign s7_pp     = 64'd1048576 - {44'b0, s6_ap_q};
  assign s8_num_d  = s7_n0_q * 64'd3125;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_vv_q   <= vv_full[63:0];
      s4_v1p5_q <= {{15{v1p5_full[48]}}, v1p5_full};
      s4_v1p2_q <= {{15{v1p2_full[48]}}, v1p2_full};
      s4_ap_q   <= s3_ap_q;
      s5_v2a_q  <= mul64x16s(s4_vv_q, p6);
      s5_vv3_q  <= mul64x16s(s4_vv_q, p3);
      s5_v1p5_q <= s4_v1p5_q;
      s5_v1p2_q <= s4_v1p2_q;
      s5_ap_q   <= s4_ap_q;
      s6_v2_q   <= s5_v2a_q + (s5_v1p5_q << 17) + (sx16_64(p4) << 35);
      s6_v1c_q  <= 64'h0000_8000_0000_0000 + asr64(s5_vv3_q, 8) + (s5_v1p2_q << 12);
      s6_ap_q   <= s5_ap_q;
      s7_m_q    <= s7_m_d;
      s7_n0_q   <= (s7_pp << 31) - s6_v2_q;
      s8_den_q  <= asr64(s7_m_q, 33);
      s8_num_q  <= s8_num_d;
    end
  end

  // signed division, one quotient bit per stage
  logic [63:0] s9_an_q, s9_ad_q;
  logic        s9_neg_q, s9_zero_q;
  logic [63:0] div_rem_q [DivBits];
  logic [63:0] div_nq_q  [DivBits];
  logic [63:0] div_ad_q  [DivBits];
  logic        div_neg_q [DivBits];
  logic        div_zero_q[DivBits];
  logic [63:0] div_rem_d [DivBits];
  logic [63:0] div_nq_d  [DivBits];

  always_comb begin
    logic [63:0] rem_in, nq_in, ad_in;
    logic [64:0] trial, diff;
    for (int k = 0; k < DivBits; k++) begin
      rem_in = (k == 0) ? 64'd0    : div_rem_q[(k == 0) ? 0 : k-1];
      nq_in  = (k == 0) ? s9_an_q  : div_nq_q[(k == 0) ? 0 : k-1];
      ad_in  = (k == 0) ? s9_ad_q  : div_ad_q[(k == 0) ? 0 : k-1];
      trial  = {rem_in, nq_in[63]};
      diff   = trial - {1'b0, ad_in};
      if (!diff[64]) begin
        div_rem_d[k] = diff[63:0];
        div_nq_d[k]  = {nq_in[62:0], 1'b1};
      end else begin
        div_rem_d[k] = trial[63:0];
        div_nq_d[k]  = {nq_in[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_neg_q  <= s8_num_q[63] ^ s8_den_q[63];
      s9_zero_q <= s8_den_q == 64'd0;
      s9_an_q   <= s8_num_q[63] ? 64'd0 - s8_num_q : s8_num_q;
      s9_ad_q   <= s8_den_q[63] ? 64'd0 - s8_den_q : s8_den_q;
      for (int k = 0; k < DivBits; k++) begin
        div_rem_q[k] <= div_rem_d[k];
        div_nq_q[k]  <= div_nq_d[k];
      end
      div_ad_q[0]   <= s9_ad_q;
      div_neg_q[0]  <= s9_neg_q;
      div_zero_q[0] <= s9_zero_q;
      for (int k = 1; k < DivBits; k++) begin
        div_ad_q[k]   <= div_ad_q[k-1];
        div_neg_q[k]  <= div_neg_q[k-1];
        div_zero_q[k] <= div_zero_q[k-1];
      end
    end
  end

  // pressure back half
  logic [63:0] s74_p_q, s75_p_q, s76_p_q, s77_p_q;
  logic        s74_z_q, s75_z_q, s76_z_q, s77_z_q, s78_z_q, s79_z_q;
  logic [63:0] s75_s13_q, s75_m1_q, s75_v2c_q, s76_v2c_q, s77_v2c_q;
  logic [63:0] s76_pl_q, s77_m2_q, s78_sum_q, s79_p2_q;
  logic [31:0] s76_c1_q, s76_c2_q, press_q;
  logic [63:0] s75_s13_d, s76_pl_d, s80_prod;
  logic signed [66:0] m1_full;
  logic [31:0] c1_d, c2_d;

  assign s75_s13_d = asr64(s74_p_q, 13);
  assign m1_full   = $signed(p9) * $signed(s75_s13_d[50:0]);
  assign s76_pl_d  = {32'b0, s75_m1_q[31:0]} * {32'b0, s75_s13_q[31:0]};
  assign c1_d      = s75_m1_q[63:32] * s75_s13_q[31:0];
  assign c2_d      = s75_m1_q[31:0] * s75_s13_q[63:32];
  assign s80_prod  = s79_p2_q * 64'd1000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s74_p_q   <= div_neg_q[DivBits-1] ? 64'd0 - div_nq_q[DivBits-1] : div_nq_q[DivBits-1];
      s74_z_q   <= div_zero_q[DivBits-1];
      s75_p_q   <= s74_p_q;
      s75_z_q   <= s74_z_q;
      s75_s13_q <= s75_s13_d;
      s75_m1_q  <= m1_full[63:0];
      s75_v2c_q <= mul64x16s(s74_p_q, p8);
      s76_p_q   <= s75_p_q;
      s76_z_q   <= s75_z_q;
      s76_v2c_q <= s75_v2c_q;
      s76_pl_q  <= s76_pl_d;
      s76_c1_q  <= c1_d;
      s76_c2_q  <= c2_d;
      s77_p_q   <= s76_p_q;
      s77_z_q   <= s76_z_q;
      s77_v2c_q <= s76_v2c_q;
      s77_m2_q  <= s76_pl_q + {s76_c1_q + s76_c2_q, 32'b0};
      s78_z_q   <= s77_z_q;
      s78_sum_q <= s77_p_q + asr64(s77_m2_q, 25) + asr64(s77_v2c_q, 19);
      s79_z_q   <= s78_z_q;
      s79_p2_q  <= asr64(s78_sum_q, 8) + (sx16_64(p7) << 4);
      press_q   <= s79_z_q ? 32'd0 : s80_prod[39:8];
    end
  end

  // humidity
  logic [31:0] h1_t0_q, h1_xr_q, h1_yr_q, h1_t0_d, h1_h5v, h1_xr_d, h1_yr_d;
  logic [31:0] h2_a_q, h2_x_q, h2_y_q;
  logic [31:0] h3_a_q, h3_xy_q, h3_xy_d;
  logic [31:0] h4_a_q, h4_z_q;
  logic [31:0] h5_a_q, h5_zh_q, h5_zh_d;
  logic [31:0] h6_a_q, h6_b_q;
  logic [31:0] h7_v_q, h7_v_d;
  logic [31:0] h8_v_q, h8_xx_q, h8_x, h8_xx_d;
  logic [31:0] h9_v_q, h9_k_q, h9_k_d;
  logic [31:0] h10_v_q, h10_sub;
  logic [31:0] h11_prod;
  logic [16:0] hum_line_q [HumLine];

  assign h1_h5v  = sx16_32(h5) * s3_hv_q;
  assign h1_t0_d = {2'b0, s3_ah_q, 14'b0} - {h4[11:0], 20'b0} - h1_h5v + 32'd16384;
  assign h1_xr_d = s3_hv_q * sx8_32(h6);
  assign h1_yr_d = s3_hv_q * {24'b0, h3};
  assign h3_xy_d = h2_x_q * h2_y_q;
  assign h5_zh_d = h4_z_q * sx16_32(h2);
  assign h7_v_d  = h6_a_q * h6_b_q;
  assign h8_x    = asr32(h7_v_q, 15);
  assign h8_xx_d = h8_x * h8_x;
  assign h9_k_d  = asr32(h8_xx_q, 7) * {24'b0, h1};
  assign h10_sub = h9_v_q - asr32(h9_k_q, 4);
  assign h11_prod = {12'b0, h10_v_q[31:12]} * 32'd1000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_t0_q <= h1_t0_d;
      h1_xr_q <= h1_xr_d;
      h1_yr_q <= h1_yr_d;
      h2_a_q  <= asr32(h1_t0_q, 15);
      h2_x_q  <= asr32(h1_xr_q, 10);
      h2_y_q  <= asr32(h1_yr_q, 11) + 32'd32768;
      h3_a_q  <= h2_a_q;
      h3_xy_q <= h3_xy_d;
      h4_a_q  <= h3_a_q;
      h4_z_q  <= asr32(h3_xy_q, 10) + 32'd2097152;
      h5_a_q  <= h4_a_q;
      h5_zh_q <= h5_zh_d + 32'd8192;
      h6_a_q  <= h5_a_q;
      h6_b_q  <= asr32(h5_zh_q, 14);
      h7_v_q  <= h7_v_d;
      h8_v_q  <= h7_v_q;
      h8_xx_q <= h8_xx_d;
      h9_v_q  <= h8_v_q;
      h9_k_q  <= h9_k_d;
      // clamp to 0..100 %RH in Q10.22
      if (h10_sub[31]) begin
        h10_v_q <= 32'd0;
      end else if (h10_sub > 32'd419430400) begin
        h10_v_q <= 32'd419430400;
      end else begin
        h10_v_q <= h10_sub;
      end
      hum_line_q[0] <= h11_prod[26:10];
      for (int k = 1; k < HumLine; k++) begin
        hum_line_q[k] <= hum_line_q[k-1];
      end
    end
  end

  assign out_valid_o = vld_q[Stages-1];
  assign temp_o      = temp_line_q[TempLine-1];
  assign press_o     = press_q;
  assign hum_o       = hum_line_q[HumLine-1];

endmodule

[rtl/core/environmental_sensor_compensation.sv]
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    raw_temperature_i, raw_pressure_i, raw_humidity_i
// output    out        out_valid_o / out_ready_i  temperature_milli_c_o, pressure_milli_pa_o,
//                                                 humidity_milli_pct_o
// config    in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// one request per cycle sustained while the output is not stalled
// latency is set by the 64-stage pressure divider, one quotient bit per stage
// reset clears calibration registers to zero and empties all stages and the queue
// an output stall freezes the compute pipeline; the front stage and queue keep
// taking requests until the queue fills
module environmental_sensor_compensation import esc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [19:0]         raw_temperature_i,
  input  logic [19:0]         raw_pressure_i,
  input  logic [15:0]         raw_humidity_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  temperature_milli_c_o,
  output logic [31:0]         pressure_milli_pa_o,
  output logic [16:0]         humidity_milli_pct_o
);

  cfg_t        cfg_q;
  logic        f_valid, f_ready, b_valid, b_ready;
  front_item_t f_item, b_item;
  logic [31:0] temp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP:    cfg_q.temp    <= cfg_wdata_i[47:0];
        CFG_PRESS_A: cfg_q.press_a <= cfg_wdata_i;
        CFG_PRESS_B: cfg_q.press_b <= cfg_wdata_i;
        CFG_MIXED:   cfg_q.mixed   <= cfg_wdata_i[47:0];
        CFG_HUM:     cfg_q.hum     <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  esc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_humidity_i    (raw_humidity_i),
    .item_valid_o      (f_valid),
    .item_o            (f_item),
    .item_ready_i      (f_ready)
  );

  esc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  esc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .temp_o       (temp),
    .press_o      (pressure_milli_pa_o),
    .hum_o        (humidity_milli_pct_o)
  );

  assign temperature_milli_c_o = $signed(temp);

endmodule
